// ===== sv/obex_header_locator_macros.svh =====
// assertion macros used by the locator walker
// every property is clocked on clk and held off while rst_n is low
`ifndef OBEX_HEADER_LOCATOR_MACROS_SVH
`define OBEX_HEADER_LOCATOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define OHL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ohl assertion failed");

// next-cycle implication
`define OHL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ohl assertion failed");

`else

`define OHL_ASSERT_NOW(label, ante, cons)
`define OHL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/ohl_pkg.sv =====
`timescale 1ns / 1ps

package ohl_pkg;

    localparam int AddrWidth = 3;
    localparam int DataWidth = 32;

    // register index taken from paddr[2]
    localparam logic REG_TARGET_ID = 1'b0;

    localparam logic [7:0] TargetIdReset = 8'd72;
    localparam logic [16:0] NhpStart = 17'd3;
    localparam logic [15:0] MinHeaderLength = 16'd3;

    // header id classes from the top two bits
    localparam logic [1:0] CLASS_PAIR = 2'b10;
    localparam logic [1:0] CLASS_QUAD = 2'b11;
    localparam logic [16:0] PairSize = 17'd2;
    localparam logic [16:0] QuadSize = 17'd5;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_ID     = 3'b001,
        PH_LEN_HI = 3'b010,
        PH_LEN_LO = 3'b100
    } phase_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [15:0] offset;
    } result_t;

endpackage

// ===== sv/ohl_cfg.sv =====
`timescale 1ns / 1ps

module ohl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ohl_pkg::AddrWidth-1:0]   paddr,
    input  logic [ohl_pkg::DataWidth-1:0]   pwdata,
    output logic [ohl_pkg::DataWidth-1:0]   prdata,
    output logic                            pready,
    output logic [7:0]                      target_id
);
    import ohl_pkg::*;

    logic [7:0] target_reg;
    logic       wr_en;
    logic       sel_target;

    assign pready     = 1'b1;
    assign sel_target = (paddr[2] == REG_TARGET_ID);
    assign wr_en      = psel && penable && pwrite && sel_target;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TargetIdReset;
        end
        else if (wr_en)
        begin
            target_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_target)
        begin
            prdata = {{(DataWidth-8){1'b0}}, target_reg};
        end
    end

    assign target_id = target_reg;

endmodule

// ===== sv/ohl_walker.sv =====
`timescale 1ns / 1ps

module ohl_walker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic             last_byte,
    input  logic [7:0]       target_id,
    output ohl_pkg::result_t res
);
    import ohl_pkg::*;

    `include "obex_header_locator_macros.svh"

    logic [15:0] byte_index_reg, byte_index_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [16:0] nhp_reg, nhp_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic        given_reg, given_next;

    // packet view after a possible restart on the opcode byte
    logic [15:0] idx;
    logic [15:0] dl;
    logic [16:0] nhp;
    phase_t      phase;
    logic [7:0]  len_hi;
    logic        given;
    logic [15:0] hdr_len;
    logic [15:0] new_dl;
    logic [16:0] nhp_sum;

    always_comb
    begin
        idx    = first_byte ? '0 : byte_index_reg;
        dl     = first_byte ? '0 : decl_len_reg;
        nhp    = first_byte ? NhpStart : nhp_reg;
        phase  = first_byte ? PH_ID : phase_reg;
        len_hi = first_byte ? '0 : len_hi_reg;
        given  = first_byte ? 1'b0 : given_reg;

        hdr_len = {len_hi, data_byte};
        new_dl  = {dl[15:8], data_byte};
        nhp_sum = nhp + {1'b0, hdr_len};

        byte_index_next = (idx != 16'hFFFF) ? idx + 16'd1 : idx;
        decl_len_next   = dl;
        nhp_next        = nhp;
        phase_next      = phase;
        len_hi_next     = len_hi;
        given_next      = given;

        res.valid  = 1'b0;
        res.status = ST_FOUND;
        res.offset = '0;

        if (!given)
        begin
            if (idx == 16'd1)
            begin
                decl_len_next = {data_byte, 8'h00};
            end
            else if (idx == 16'd2)
            begin
                decl_len_next = new_dl;
                if (nhp >= {1'b0, new_dl})
                begin
                    res.valid  = 1'b1;
                    res.status = ST_ABSENT;
                end
            end
            else if (idx >= 16'd3)
            begin
                case (phase)
                    PH_LEN_HI:
                    begin
                        len_hi_next = data_byte;
                        phase_next  = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        phase_next = PH_ID;
                        if (hdr_len < MinHeaderLength)
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_MALFORMED;
                        end
                        else
                        begin
                            nhp_next = nhp_sum;
                            if (nhp_sum >= {1'b0, dl})
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_ABSENT;
                            end
                        end
                    end
                    PH_ID:
                    begin
                        if ({1'b0, idx} == nhp)
                        begin
                            if (data_byte == target_id)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_FOUND;
                                res.offset = idx + 16'd1;
                            end
                            else if (data_byte[7:6] == CLASS_PAIR
                                     || data_byte[7:6] == CLASS_QUAD)
                            begin
                                // fixed-size header, skip it whole
                                nhp_next = nhp + ((data_byte[7:6] == CLASS_PAIR)
                                                  ? PairSize : QuadSize);
                                if (nhp_next >= {1'b0, dl})
                                begin
                                    res.valid  = 1'b1;
                                    res.status = ST_ABSENT;
                                end
                            end
                            else
                            begin
                                phase_next = PH_LEN_HI;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ID;
                    end
                endcase
            end

            if (!res.valid && last_byte)
            begin
                res.valid  = 1'b1;
                res.status = ST_TRUNCATED;
            end

            if (res.valid)
            begin
                given_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            decl_len_reg   <= '0;
            nhp_reg        <= NhpStart;
            phase_reg      <= PH_ID;
            len_hi_reg     <= '0;
            given_reg      <= 1'b0;
        end
        else if (fire)
        begin
            byte_index_reg <= byte_index_next;
            decl_len_reg   <= decl_len_next;
            nhp_reg        <= nhp_next;
            phase_reg      <= phase_next;
            len_hi_reg     <= len_hi_next;
            given_reg      <= given_next;
        end
    end

    // one result per packet
    `OHL_ASSERT_NOW(a_one_result, fire && given_reg && !first_byte, !res.valid)
    `OHL_ASSERT_NEXT(a_given_set, fire && res.valid, given_reg)
    `OHL_ASSERT_NOW(a_offset_zero, res.valid && res.status != ST_FOUND, res.offset == 16'd0)
    `OHL_ASSERT_NEXT(a_index_step, fire && first_byte, byte_index_reg == 16'd1)

endmodule

// ===== sv/obex_header_locator.sv =====
`timescale 1ns / 1ps

// obex header locator
// bytes of an obex packet come in on the byte channel (byte_valid / byte_stall)
// with data_byte, first_byte on the opcode byte and last_byte on the final one.
// one result per packet leaves on the result channel (result_valid /
// result_stall) as status and value_offset; found gives the index just past
// the matching header id. the header id searched for sits in the apb register
// at address 0 (target_id, reset 0x48).
// one byte is taken every cycle while byte_stall is low; a byte passes an
// input register and its result is registered in the output register.
// the walk over one byte is a compare and a 17-bit add between those two.
// when the output register holds a result and result_stall is high, a byte
// in the input register is held and byte_stall rises until the result leaves.
// reset clears the valid flags of both registers and starts a fresh packet; a
// stream that starts without first_byte is taken as a new packet.
module obex_header_locator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    output logic                            byte_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            first_byte,
    input  logic                            last_byte,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [1:0]                      status,
    output logic [15:0]                     value_offset,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ohl_pkg::AddrWidth-1:0]   paddr,
    input  logic [ohl_pkg::DataWidth-1:0]   pwdata,
    output logic [ohl_pkg::DataWidth-1:0]   prdata,
    output logic                            pready
);
    import ohl_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_first_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [15:0] out_offset_reg;

    logic        advance;
    logic        fire;
    logic [7:0]  target_id;
    result_t     res;

    ohl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .target_id (target_id)
    );

    // output register free or emptying this cycle
    assign advance    = !out_valid_reg || !result_stall;
    assign fire       = in_valid_reg && advance;
    assign byte_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_data_reg  <= data_byte;
            in_first_reg <= first_byte;
            in_last_reg  <= last_byte;
        end
    end

    ohl_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .last_byte  (in_last_reg),
        .target_id  (target_id),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= res.valid;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.valid)
        begin
            out_status_reg <= res.status;
            out_offset_reg <= res.offset;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign value_offset = out_offset_reg;

endmodule
